### rtl/core/lsms_pkg.sv
// shared types, access kind codes and helper functions for the block transfer sequencer
package lsms_pkg;

	localparam int unsigned ListWidth = 16;
	localparam int unsigned IdxWidth  = 4;
	localparam int unsigned AddrWidth = 32;
	localparam int unsigned CntWidth  = 5;

	localparam logic [AddrWidth-1:0] EMPTY_LIST_STEP = 32'h0000_0040;
	localparam logic [AddrWidth-1:0] WORD_STEP       = 32'h0000_0004;
	localparam logic [IdxWidth-1:0]  PC_INDEX        = 4'd15;

	typedef logic [3:0] kind_t;
	localparam kind_t KIND_LD         = 4'd0;
	localparam kind_t KIND_LD_USER    = 4'd1;
	localparam kind_t KIND_LD_PC      = 4'd2;
	localparam kind_t KIND_LD_PC_RST  = 4'd3;
	localparam kind_t KIND_LD_PC_RAW  = 4'd4;
	localparam kind_t KIND_ST         = 4'd5;
	localparam kind_t KIND_ST_USER    = 4'd6;
	localparam kind_t KIND_ST_NEWBASE = 4'd7;
	localparam kind_t KIND_ST_PC4     = 4'd8;
	localparam kind_t KIND_ST_PC      = 4'd9;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SETUP,
		ST_RUN
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic load_item;
		logic setup;
		logic emit;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic out_free;
		logic final_word;
	} sts_t;

	function automatic logic [CntWidth-1:0] count_ones(input logic [ListWidth-1:0] v);
		logic [CntWidth-1:0] c;
		c = '0;
		for (int i = 0; i < ListWidth; i++) begin
			c = c + CntWidth'(v[i]);
		end
		return c;
	endfunction

	// priority encoder, lowest set bit wins
	function automatic logic [IdxWidth-1:0] lowest_index(input logic [ListWidth-1:0] v);
		logic [IdxWidth-1:0] idx;
		idx = '0;
		for (int i = ListWidth - 1; i >= 0; i--) begin
			if (v[i]) begin
				idx = IdxWidth'(i);
			end
		end
		return idx;
	endfunction

endpackage

### rtl/core/lsms_ctrl.sv
// controller state machine for the block transfer sequencer
module lsms_ctrl
	import lsms_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  sts_t sts,
	output cmd_t cmd
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		cmd.load_item = 1'b0;
		cmd.setup     = 1'b0;
		cmd.emit      = 1'b0;
		in_stall      = 1'b1;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.load_item = 1'b1;
					state_d       = ST_SETUP;
				end
			end
			ST_SETUP: begin
				cmd.setup = 1'b1;
				state_d   = ST_RUN;
			end
			ST_RUN: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					if (sts.final_word) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	a_emit_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> sts.out_free)
		else $error("word emitted into a full output register");

	a_one_command: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.load_item, cmd.setup, cmd.emit}))
		else $error("more than one command at once");

	a_setup_after_load: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_item |=> cmd.setup)
		else $error("setup did not follow item load");

	a_final_returns_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit && sts.final_word) |=> !in_stall)
		else $error("input still stalled after final word");

endmodule

### rtl/core/lsms_dp.sv
// datapath: instruction registers, address stepping and output register
module lsms_dp
	import lsms_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  cmd_t                 cmd,
	output sts_t                 sts,
	input  logic                 mode,
	input  logic [ListWidth-1:0] register_list,
	input  logic [IdxWidth-1:0]  base_index,
	input  logic                 pre_index,
	input  logic                 up,
	input  logic                 s_bit,
	input  logic                 write_back,
	input  logic [AddrWidth-1:0] base_value,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [AddrWidth-1:0] access_address,
	output logic [IdxWidth-1:0]  register_index,
	output logic [3:0]           access_kind,
	output logic [AddrWidth-1:0] new_base,
	output logic                 base_update,
	output logic                 last
);

	logic                 store_q;
	logic [ListWidth-1:0] list_q;
	logic [ListWidth-1:0] rem_q;
	logic [IdxWidth-1:0]  base_idx_q;
	logic                 pre_q;
	logic                 up_q;
	logic                 sb_q;
	logic                 wb_q;
	logic [AddrWidth-1:0] base_q;
	logic [CntWidth-1:0]  cnt_q;
	logic [AddrWidth-1:0] addr_q;
	logic [AddrWidth-1:0] nb_q;
	logic                 upd_q;
	logic                 first_q;
	logic                 empty_q;
	logic                 out_valid_q;

	logic [AddrWidth-1:0] span;
	logic [IdxWidth-1:0]  cur_idx;
	logic                 final_word;
	kind_t                cur_kind;

	assign span       = {{(AddrWidth-CntWidth-2){1'b0}}, cnt_q, 2'b00};
	assign cur_idx    = empty_q ? PC_INDEX : lowest_index(rem_q);
	assign final_word = empty_q || ((rem_q & (rem_q - 16'd1)) == '0);

	assign sts.out_free   = !out_valid_q || !out_stall;
	assign sts.final_word = final_word;

	always_comb begin
		if (empty_q) begin
			cur_kind = store_q ? KIND_ST_PC : KIND_LD_PC_RAW;
		end else if (store_q) begin
			if (cur_idx == PC_INDEX) begin
				cur_kind = KIND_ST_PC4;
			end else if (!first_q && cur_idx == base_idx_q && wb_q) begin
				cur_kind = KIND_ST_NEWBASE;
			end else begin
				cur_kind = sb_q ? KIND_ST_USER : KIND_ST;
			end
		end else begin
			if (cur_idx == PC_INDEX) begin
				cur_kind = sb_q ? KIND_LD_PC_RST : KIND_LD_PC;
			end else if (sb_q && !list_q[PC_INDEX]) begin
				cur_kind = KIND_LD_USER;
			end else begin
				cur_kind = KIND_LD;
			end
		end
	end

	// instruction registers
	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			store_q    <= mode;
			list_q     <= register_list;
			base_idx_q <= base_index;
			pre_q      <= pre_index;
			up_q       <= up;
			sb_q       <= s_bit;
			wb_q       <= write_back;
			base_q     <= base_value;
			cnt_q      <= count_ones(register_list);
		end
	end

	// start address, final base and writeback flag; the address steps one word per emitted word
	always_ff @(posedge clk) begin
		if (cmd.setup) begin
			if (cnt_q == '0) begin
				addr_q <= base_q;
				nb_q   <= base_q + EMPTY_LIST_STEP;
				upd_q  <= 1'b1;
			end else begin
				case ({pre_q, up_q})
					2'b00:   addr_q <= base_q - span + WORD_STEP;
					2'b01:   addr_q <= base_q;
					2'b10:   addr_q <= base_q - span;
					default: addr_q <= base_q + WORD_STEP;
				endcase
				nb_q  <= up_q ? base_q + span : base_q - span;
				upd_q <= store_q ? wb_q : (wb_q && !list_q[base_idx_q]);
			end
		end else if (cmd.emit) begin
			addr_q <= addr_q + WORD_STEP;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q   <= '0;
			first_q <= 1'b0;
			empty_q <= 1'b0;
		end else if (cmd.setup) begin
			rem_q   <= list_q;
			first_q <= 1'b1;
			empty_q <= (cnt_q == '0);
		end else if (cmd.emit) begin
			rem_q   <= rem_q & (rem_q - 16'd1);
			first_q <= 1'b0;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			access_address <= addr_q;
			register_index <= cur_idx;
			access_kind    <= cur_kind;
			new_base       <= nb_q;
			base_update    <= final_word ? upd_q : 1'b0;
			last           <= final_word;
		end
	end

	assign out_valid = out_valid_q;

endmodule

### rtl/core/load_store_multiple_sequencer_unit.sv
// top level of the load / store multiple address sequencer
//
//  channel | direction | handshake             | payload
//  in      | input     | in_valid / in_stall   | mode, register_list, base_index, pre_index,
//          |           |                       | up, s_bit, write_back, base_value
//  out     | output    | out_valid / out_stall | access_address, register_index, access_kind,
//          |           |                       | new_base, base_update, last
//
// an instruction is loaded with its bit count, then the start address is added, then one word per listed
// register (a single pc word for an empty list) leaves the single output register, one output word per
// cycle while out_stall stays low
// in_stall is high from acceptance until the final word enters the output register
// out_stall holds the output register and pauses the sequence
// arst_n clears the state machine and output valid; the block is idle after reset
module load_store_multiple_sequencer_unit
	import lsms_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic                 mode,
	input  logic [ListWidth-1:0] register_list,
	input  logic [IdxWidth-1:0]  base_index,
	input  logic                 pre_index,
	input  logic                 up,
	input  logic                 s_bit,
	input  logic                 write_back,
	input  logic [AddrWidth-1:0] base_value,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [AddrWidth-1:0] access_address,
	output logic [IdxWidth-1:0]  register_index,
	output logic [3:0]           access_kind,
	output logic [AddrWidth-1:0] new_base,
	output logic                 base_update,
	output logic                 last
);

	cmd_t cmd;
	sts_t sts;

	lsms_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	lsms_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.mode           (mode),
		.register_list  (register_list),
		.base_index     (base_index),
		.pre_index      (pre_index),
		.up             (up),
		.s_bit          (s_bit),
		.write_back     (write_back),
		.base_value     (base_value),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.access_address (access_address),
		.register_index (register_index),
		.access_kind    (access_kind),
		.new_base       (new_base),
		.base_update    (base_update),
		.last           (last)
	);

endmodule

### bench/tb_top.sv
// self-checking testbench for the load / store multiple address sequencer
`timescale 1ns / 100ps

module tb_top;
	import lsms_pkg::*;

	localparam int unsigned IDLE_PCT     = 34;
	localparam int unsigned RANDOM_WORDS = 258;
	localparam int unsigned STALL_LIMIT  = 3000;
	localparam int unsigned TAIL_CYCLES  = 24;

	typedef struct packed {
		logic                 mode;
		logic [ListWidth-1:0] register_list;
		logic [IdxWidth-1:0]  base_index;
		logic                 pre_index;
		logic                 up;
		logic                 s_bit;
		logic                 write_back;
		logic [AddrWidth-1:0] base_value;
	} xfer_t;

	typedef struct packed {
		logic [AddrWidth-1:0] addr;
		logic [IdxWidth-1:0]  reg_idx;
		kind_t                kind;
		logic [AddrWidth-1:0] nb;
		logic                 upd;
		logic                 fin;
	} access_t;

	typedef struct packed {
		xfer_t   w;
		logic    typed;
		access_t exp;
	} row_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	logic                 mode = 1'b0;
	logic [ListWidth-1:0] register_list = '0;
	logic [IdxWidth-1:0]  base_index = '0;
	logic                 pre_index = 1'b0;
	logic                 up = 1'b0;
	logic                 s_bit = 1'b0;
	logic                 write_back = 1'b0;
	logic [AddrWidth-1:0] base_value = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic [AddrWidth-1:0] access_address;
	logic [IdxWidth-1:0]  register_index;
	logic [3:0]           access_kind;
	logic [AddrWidth-1:0] new_base;
	logic                 base_update;
	logic                 last;

	access_t     pending_accesses[$];
	row_t        directed_rows[$];
	int unsigned mismatch_count = 0;
	int unsigned idle_run = 0;
	bit          steady_run = 1'b0;

	load_store_multiple_sequencer_unit i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.mode           (mode),
		.register_list  (register_list),
		.base_index     (base_index),
		.pre_index      (pre_index),
		.up             (up),
		.s_bit          (s_bit),
		.write_back     (write_back),
		.base_value     (base_value),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.access_address (access_address),
		.register_index (register_index),
		.access_kind    (access_kind),
		.new_base       (new_base),
		.base_update    (base_update),
		.last           (last)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic xfer_t xf(input logic m, input logic [ListWidth-1:0] list,
			input logic [IdxWidth-1:0] bidx, input logic p, input logic u, input logic s,
			input logic w, input logic [AddrWidth-1:0] base);
		xfer_t x;
		x = '{m, list, bidx, p, u, s, w, base};
		return x;
	endfunction

	function automatic access_t acc(input logic [AddrWidth-1:0] addr,
			input logic [IdxWidth-1:0] ridx, input kind_t kd, input logic [AddrWidth-1:0] nb,
			input logic upd, input logic fin);
		access_t a;
		a = '{addr, ridx, kd, nb, upd, fin};
		return a;
	endfunction

	// expands one block transfer into the bus accesses it should produce
	task automatic expand_transfer(input xfer_t w);
		int unsigned          cnt;
		int unsigned          k;
		logic [AddrWidth-1:0] span;
		logic [AddrWidth-1:0] addr;
		logic [AddrWidth-1:0] nb;
		logic                 upd;
		kind_t                kd;
		cnt = 0;
		for (int i = 0; i < ListWidth; i++) begin
			cnt += w.register_list[i];
		end
		if (cnt == 0) begin
			// empty list: a single pc access at the base, base grows by sixteen words
			pending_accesses.push_back(acc(w.base_value, PC_INDEX,
				w.mode ? KIND_ST_PC : KIND_LD_PC_RAW, w.base_value + EMPTY_LIST_STEP,
				1'b1, 1'b1));
		end else begin
			span = AddrWidth'(cnt) << 2;
			case ({w.pre_index, w.up})
				2'b00: addr = w.base_value - span + WORD_STEP;
				2'b01: addr = w.base_value;
				2'b10: addr = w.base_value - span;
				default: addr = w.base_value + WORD_STEP;
			endcase
			nb = w.up ? w.base_value + span : w.base_value - span;
			// a load that refills its own base register drops the writeback
			upd = w.mode ? w.write_back : (w.write_back && !w.register_list[w.base_index]);
			k = 0;
			for (int i = 0; i < ListWidth; i++) begin
				if (w.register_list[i]) begin
					if (w.mode) begin
						if (i == PC_INDEX)
							kd = KIND_ST_PC4;
						else if (k != 0 && i == w.base_index && w.write_back)
							kd = KIND_ST_NEWBASE;
						else
							kd = w.s_bit ? KIND_ST_USER : KIND_ST;
					end else begin
						if (i == PC_INDEX)
							kd = w.s_bit ? KIND_LD_PC_RST : KIND_LD_PC;
						else if (w.s_bit && !w.register_list[PC_INDEX])
							kd = KIND_LD_USER;
						else
							kd = KIND_LD;
					end
					k++;
					pending_accesses.push_back(acc(addr, IdxWidth'(i), kd, nb,
						(k == cnt) ? upd : 1'b0, k == cnt));
					addr += WORD_STEP;
				end
			end
		end
	endtask

	task automatic drive_fields(input xfer_t w);
		mode          = w.mode;
		register_list = w.register_list;
		base_index    = w.base_index;
		pre_index     = w.pre_index;
		up            = w.up;
		s_bit         = w.s_bit;
		write_back    = w.write_back;
		base_value    = w.base_value;
	endtask

	// called at a falling edge; returns at the falling edge after the word is taken
	task automatic issue_transfer(input xfer_t w, input logic typed, input access_t exp);
		while (!steady_run && $urandom_range(0, 99) < IDLE_PCT) begin
			in_valid = 1'b0;
			drive_fields(xf(1'($urandom), ListWidth'($urandom), IdxWidth'($urandom),
				1'($urandom), 1'($urandom), 1'($urandom), 1'($urandom), $urandom));
			@(negedge clk);
		end
		drive_fields(w);
		in_valid = 1'b1;
		do begin
			@(posedge clk);
		end while (in_stall);
		if (typed)
			pending_accesses.push_back(exp);
		else
			expand_transfer(w);
		@(negedge clk);
	endtask

	task automatic drain_accesses();
		in_valid = 1'b0;
		while (pending_accesses.size() != 0) begin
			@(negedge clk);
		end
	endtask

	function automatic xfer_t random_transfer();
		xfer_t                w;
		int unsigned          shape;
		int unsigned          pick;
		logic [ListWidth-1:0] list;
		w = xf(1'($urandom), ListWidth'($urandom), IdxWidth'($urandom_range(0, 14)),
			1'($urandom), 1'($urandom), 1'($urandom), 1'($urandom), $urandom);
		shape = $urandom_range(0, 99);
		if (shape < 5) begin
			list = '0;
		end else if (shape < 35) begin
			list = '0;
			pick = $urandom_range(1, 3);
			for (int i = 0; i < pick; i++) begin
				list[$urandom_range(0, ListWidth - 1)] = 1'b1;
			end
		end else if (shape < 55) begin
			list = ListWidth'($urandom);
		end else if (shape < 70) begin
			// base register listed, with a neighbour below it now and then
			list = ListWidth'($urandom) & ListWidth'($urandom);
			list[w.base_index] = 1'b1;
			if (w.base_index != 0 && $urandom_range(0, 1))
				list[w.base_index - 1] = 1'b1;
		end else if (shape < 85) begin
			list = ListWidth'($urandom) & ListWidth'($urandom) & ListWidth'($urandom);
			list[PC_INDEX] = 1'b1;
		end else if (shape < 93) begin
			list = 16'hFFFF;
		end else begin
			list = 16'h7FFF;
		end
		w.register_list = list;
		pick = $urandom_range(0, 99);
		if (pick < 25)
			w.base_value = 32'hFFFF_FF00 | AddrWidth'($urandom_range(0, 255));
		else if (pick < 40)
			w.base_value = AddrWidth'($urandom_range(0, 255));
		return w;
	endfunction

	always @(negedge clk) begin
		out_stall <= !steady_run && ($urandom_range(0, 99) < IDLE_PCT);
	end

	always @(posedge clk) begin
		access_t exp;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_accesses.size() == 0) begin
				$error("unexpected word: access_address %h register_index %0d",
					access_address, register_index);
				mismatch_count++;
			end else begin
				exp = pending_accesses.pop_front();
				if (access_address !== exp.addr) begin
					$error("access_address: expected %h, got %h", exp.addr, access_address);
					mismatch_count++;
				end
				if (register_index !== exp.reg_idx) begin
					$error("register_index: expected %0d, got %0d", exp.reg_idx,
						register_index);
					mismatch_count++;
				end
				if (access_kind !== exp.kind) begin
					$error("access_kind: expected %0d, got %0d", exp.kind, access_kind);
					mismatch_count++;
				end
				if (new_base !== exp.nb) begin
					$error("new_base: expected %h, got %h", exp.nb, new_base);
					mismatch_count++;
				end
				if (base_update !== exp.upd) begin
					$error("base_update: expected %b, got %b", exp.upd, base_update);
					mismatch_count++;
				end
				if (last !== exp.fin) begin
					$error("last: expected %b, got %b", exp.fin, last);
					mismatch_count++;
				end
			end
		end
	end

	// watchdog on cycles with no word moving on either side
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			idle_run <= 0;
		end else if (idle_run >= STALL_LIMIT) begin
			$display("Verification failed");
			$finish;
		end else begin
			idle_run <= idle_run + 1;
		end
	end

	initial begin
		// empty lists and single-register rows carry their expected word directly
		directed_rows.push_back('{xf(1'b0, 16'h0000, 4'd0, 1'b0, 1'b1, 1'b0, 1'b0,
			32'h1000_0000), 1'b1, acc(32'h1000_0000, PC_INDEX, KIND_LD_PC_RAW,
			32'h1000_0040, 1'b1, 1'b1)});
		directed_rows.push_back('{xf(1'b1, 16'h0000, 4'd14, 1'b1, 1'b0, 1'b1, 1'b1,
			32'hFFFF_FFF0), 1'b1, acc(32'hFFFF_FFF0, PC_INDEX, KIND_ST_PC,
			32'h0000_0030, 1'b1, 1'b1)});
		directed_rows.push_back('{xf(1'b0, 16'h0000, 4'd7, 1'b1, 1'b1, 1'b1, 1'b1,
			32'hFFFF_FFFF), 1'b1, acc(32'hFFFF_FFFF, PC_INDEX, KIND_LD_PC_RAW,
			32'h0000_003F, 1'b1, 1'b1)});
		directed_rows.push_back('{xf(1'b0, 16'h0001, 4'd2, 1'b0, 1'b1, 1'b0, 1'b1,
			32'h0000_0000), 1'b1, acc(32'h0000_0000, 4'd0, KIND_LD,
			32'h0000_0004, 1'b1, 1'b1)});
		directed_rows.push_back('{xf(1'b1, 16'h8000, 4'd0, 1'b1, 1'b0, 1'b0, 1'b0,
			32'h0000_0000), 1'b1, acc(32'hFFFF_FFFC, PC_INDEX, KIND_ST_PC4,
			32'hFFFF_FFFC, 1'b0, 1'b1)});
		directed_rows.push_back('{xf(1'b1, 16'h4000, 4'd14, 1'b0, 1'b1, 1'b1, 1'b1,
			32'h0000_0080), 1'b1, acc(32'h0000_0080, 4'd14, KIND_ST_USER,
			32'h0000_0084, 1'b1, 1'b1)});
		// the rest goes through the predictor
		directed_rows.push_back('{xf(1'b0, 16'hFFFF, 4'd3, 1'b0, 1'b1, 1'b0, 1'b1,
			32'h0000_1000), 1'b0, '0});
		directed_rows.push_back('{xf(1'b1, 16'hFFFF, 4'd0, 1'b1, 1'b1, 1'b0, 1'b1,
			32'hFFFF_FFC0), 1'b0, '0});
		directed_rows.push_back('{xf(1'b0, 16'hFFFF, 4'd9, 1'b0, 1'b0, 1'b1, 1'b0,
			32'h0000_0020), 1'b0, '0});
		directed_rows.push_back('{xf(1'b0, 16'h7FFF, 4'd8, 1'b1, 1'b0, 1'b1, 1'b1,
			32'h8000_0000), 1'b0, '0});
		directed_rows.push_back('{xf(1'b1, 16'h00FF, 4'd12, 1'b0, 1'b1, 1'b1, 1'b0,
			32'h0000_4000), 1'b0, '0});
		directed_rows.push_back('{xf(1'b1, 16'h0030, 4'd5, 1'b0, 1'b1, 1'b0, 1'b1,
			32'h0000_0100), 1'b0, '0});
		directed_rows.push_back('{xf(1'b1, 16'h0030, 4'd4, 1'b0, 1'b1, 1'b0, 1'b1,
			32'h0000_0100), 1'b0, '0});
		directed_rows.push_back('{xf(1'b1, 16'h0030, 4'd5, 1'b0, 1'b1, 1'b0, 1'b0,
			32'h0000_0100), 1'b0, '0});
		directed_rows.push_back('{xf(1'b0, 16'h4000, 4'd14, 1'b0, 1'b1, 1'b0, 1'b1,
			32'h0000_0200), 1'b0, '0});
		directed_rows.push_back('{xf(1'b0, 16'h3FFF, 4'd14, 1'b1, 1'b1, 1'b0, 1'b1,
			32'h0000_0200), 1'b0, '0});
		directed_rows.push_back('{xf(1'b1, 16'h00F0, 4'd1, 1'b0, 1'b0, 1'b0, 1'b1,
			32'h0000_0008), 1'b0, '0});
		directed_rows.push_back('{xf(1'b0, 16'h0007, 4'd10, 1'b1, 1'b1, 1'b0, 1'b1,
			32'hFFFF_FFF8), 1'b0, '0});
		directed_rows.push_back('{xf(1'b0, 16'h8001, 4'd6, 1'b0, 1'b1, 1'b0, 1'b1,
			32'hFFFF_FFFF), 1'b0, '0});
		directed_rows.push_back('{xf(1'b0, 16'h8000, 4'd11, 1'b1, 1'b0, 1'b1, 1'b1,
			32'h0000_0004), 1'b0, '0});
		directed_rows.push_back('{xf(1'b1, 16'hC000, 4'd14, 1'b1, 1'b0, 1'b1, 1'b1,
			32'h0000_0000), 1'b0, '0});
		directed_rows.push_back('{xf(1'b1, 16'h8200, 4'd9, 1'b1, 1'b1, 1'b1, 1'b1,
			32'h7FFF_FFFC), 1'b0, '0});

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (directed_rows[r]) begin
			issue_transfer(directed_rows[r].w, directed_rows[r].typed, directed_rows[r].exp);
		end
		// hold the next word back until the sequencer has emptied
		drain_accesses();

		for (int unsigned n = 0; n < RANDOM_WORDS; n++) begin
			steady_run = (n >= 100 && n < 160);
			if (n == 200)
				drain_accesses();
			issue_transfer(random_transfer(), 1'b0, '0);
		end
		steady_run = 1'b0;
		drain_accesses();
		repeat (TAIL_CYCLES) @(posedge clk);

		if (mismatch_count == 0 && pending_accesses.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

### filelist.f
rtl/core/lsms_pkg.sv
rtl/core/lsms_ctrl.sv
rtl/core/lsms_dp.sv
rtl/core/load_store_multiple_sequencer_unit.sv
bench/tb_top.sv
